// ===== rtl/rbo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbo_pkg
// Shared widths, fixed-point formats and helpers of the rotated box overlap test.
// ----------------------------------------------------------------------------
package rbo_pkg;

  // Packed field widths on the stream
  localparam int VEC_W  = 48;   // three coordinate lanes
  localparam int QUAT_W = 64;   // four quaternion lanes
  localparam int QL_W   = 16;   // one quaternion lane, Q1.14

  // Fixed-point formats
  localparam int COORD_FRAC = 8;
  localparam int HALF_FRAC  = 17;
  localparam int ROT_FRAC   = 14;
  localparam int EXT_SHIFT  = HALF_FRAC + ROT_FRAC - COORD_FRAC;

  // Rotation matrix entry before rounding: Q.28, signed, 35 bits
  localparam int RM_W = 35;
  // |R| entry after rounding to 14 fraction bits
  localparam int ROT_W = 19;

  localparam logic signed [RM_W-1:0] ONE_Q28 = 35'sd268435456;

  // |v| rounded half up from 28 to 14 fraction bits
  function automatic logic [ROT_W-1:0] abs_round14(input logic signed [RM_W-1:0] v);
    logic [RM_W-1:0] mag;
    logic [RM_W-1:0] rnd;
    mag = v[RM_W-1] ? RM_W'(-v) : RM_W'(v);
    rnd = mag + RM_W'(1 << (28 - ROT_FRAC - 1));
    return rnd[28-ROT_FRAC +: ROT_W];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rotated_box_overlap_test_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one box pair per cycle while the master side does not stall; the
// pipeline depth is set by the five bounds stages (products, matrix, weighting,
// sum, saturate) plus the compare. A stall on the master side freezes all
// stages together.
// Reset (rst_ni low, asynchronous) clears the valid bits; data needs no reset.
// ----------------------------------------------------------------------------
// rotated_box_overlap_test_unit
// Overlap test of the axis-aligned bounds of two rotated, scaled boxes.
// ----------------------------------------------------------------------------
module rotated_box_overlap_test_unit import rbo_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // center_a, size_a, scale_a, orient_a, center_b, size_b, scale_b, orient_b
  input  wire  [415:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // overlap_x, overlap_y, overlap_z, colliding, 4 bits zero
  output logic [7:0]   m_axis_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int BOX_W  = 3 * VEC_W + QUAT_W;
  localparam int NSTAGE = 5;

  logic en;
  logic [NSTAGE-1:0] v_q;
  logic              ov_q;
  logic [3:0]        res_q;

  // Whole pipe advances unless the output holds an untaken result
  assign en            = !ov_q || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [CW-1:0] mna [3], mxa [3], mnb [3], mxb [3];

  rbo_box_bounds #(.CW(CW)) u_box_a (
    .clk_i    (clk_i),
    .en_i     (en),
    .center_i (s_axis_tdata[0*VEC_W +: VEC_W]),
    .size_i   (s_axis_tdata[1*VEC_W +: VEC_W]),
    .scale_i  (s_axis_tdata[2*VEC_W +: VEC_W]),
    .orient_i (s_axis_tdata[3*VEC_W +: QUAT_W]),
    .min_o    (mna),
    .max_o    (mxa)
  );

  rbo_box_bounds #(.CW(CW)) u_box_b (
    .clk_i    (clk_i),
    .en_i     (en),
    .center_i (s_axis_tdata[BOX_W + 0*VEC_W +: VEC_W]),
    .size_i   (s_axis_tdata[BOX_W + 1*VEC_W +: VEC_W]),
    .scale_i  (s_axis_tdata[BOX_W + 2*VEC_W +: VEC_W]),
    .orient_i (s_axis_tdata[BOX_W + 3*VEC_W +: QUAT_W]),
    .min_o    (mnb),
    .max_o    (mxb)
  );

  // Per-axis overlap, touching counts
  logic [2:0] ovl;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ovl[i] = (mna[i] <= mxb[i]) && (mxa[i] >= mnb[i]);
    end
  end

  // Valid bits alongside the bounds stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[NSTAGE-2:0], s_axis_tvalid};
      ov_q <= v_q[NSTAGE-1];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= {&ovl, ovl};
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0000, res_q};

endmodule
`default_nettype wire

// ===== rtl/rbo_box_bounds.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbo_box_bounds
// Five-stage pipeline from one box (center, size, scale, quaternion) to its
// world-space axis-aligned min and max bounds.
// ----------------------------------------------------------------------------
module rbo_box_bounds import rbo_pkg::*; #(
  parameter int CW = 16
) (
  input  wire                    clk_i,
  input  wire                    en_i,
  input  wire  [VEC_W-1:0]       center_i,
  input  wire  [VEC_W-1:0]       size_i,
  input  wire  [VEC_W-1:0]       scale_i,
  input  wire  [QUAT_W-1:0]      orient_i,
  output logic signed [CW-1:0]   min_o [3],
  output logic signed [CW-1:0]   max_o [3]
);

  localparam int LW = (3 * CW > VEC_W) ? 3 * CW : VEC_W;
  localparam int HW = CW + 9;             // saturated half extent
  localparam int MW = (2 * CW > HW) ? 2 * CW : HW;
  localparam int PW = ROT_W + HW;         // |R| * half
  localparam int SW = PW + 2;             // sum of three products
  localparam int EW = SW - EXT_SHIFT;     // extent, 8 fraction bits
  localparam int DW = EW + 2;             // center -/+ extent

  localparam logic [HW-1:0] HALF_CAP = {HW{1'b1}};
  localparam logic signed [DW-1:0] SMAX = DW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [DW-1:0] SMIN = ~SMAX;

  // Lane extraction; lanes past the field read as zero
  logic [LW-1:0] ctr_w, size_w, scale_w;
  assign ctr_w   = LW'(center_i);
  assign size_w  = LW'(size_i);
  assign scale_w = LW'(scale_i);

  logic signed [QL_W-1:0] qw, qx, qy, qz;
  assign qw = orient_i[0*QL_W +: QL_W];
  assign qx = orient_i[1*QL_W +: QL_W];
  assign qy = orient_i[2*QL_W +: QL_W];
  assign qz = orient_i[3*QL_W +: QL_W];

  // Stage 1: quaternion products and size*scale
  logic [2*CW-1:0]            hp_q [3];
  logic signed [2*QL_W-1:0]   xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [CW-1:0]       c1_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        hp_q[i] <= (2*CW)'(size_w[i*CW +: CW]) * (2*CW)'(scale_w[i*CW +: CW]);
        c1_q[i] <= ctr_w[i*CW +: CW];
      end
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      xy_q <= qx * qy;
      xz_q <= qx * qz;
      yz_q <= qy * qz;
      wx_q <= qw * qx;
      wy_q <= qw * qy;
      wz_q <= qw * qz;
    end
  end

  // Stage 2: rotation matrix, absolute value and rounding; half saturation
  logic signed [RM_W-1:0] rm [3][3];
  always_comb begin
    rm[0][0] = ONE_Q28 - ((RM_W'(yy_q) + RM_W'(zz_q)) <<< 1);
    rm[0][1] = (RM_W'(xy_q) - RM_W'(wz_q)) <<< 1;
    rm[0][2] = (RM_W'(xz_q) + RM_W'(wy_q)) <<< 1;
    rm[1][0] = (RM_W'(xy_q) + RM_W'(wz_q)) <<< 1;
    rm[1][1] = ONE_Q28 - ((RM_W'(xx_q) + RM_W'(zz_q)) <<< 1);
    rm[1][2] = (RM_W'(yz_q) - RM_W'(wx_q)) <<< 1;
    rm[2][0] = (RM_W'(xz_q) - RM_W'(wy_q)) <<< 1;
    rm[2][1] = (RM_W'(yz_q) + RM_W'(wx_q)) <<< 1;
    rm[2][2] = ONE_Q28 - ((RM_W'(xx_q) + RM_W'(yy_q)) <<< 1);
  end

  logic [ROT_W-1:0]     ar_q [3][3];
  logic [HW-1:0]        half_q [3];
  logic signed [CW-1:0] c2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ar_q[i][j] <= abs_round14(rm[i][j]);
        end
        half_q[i] <= (MW'(hp_q[i]) > MW'(HALF_CAP)) ? HALF_CAP : HW'(hp_q[i]);
        c2_q[i]   <= c1_q[i];
      end
    end
  end

  // Stage 3: |R| times half extents
  logic [PW-1:0]        pr_q [3][3];
  logic signed [CW-1:0] c3_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[i][j] <= PW'(ar_q[i][j]) * PW'(half_q[j]);
        end
        c3_q[i] <= c2_q[i];
      end
    end
  end

  // Stage 4: row sums, rounded half up to 8 fraction bits
  logic [SW-1:0]        sum [3];
  logic [EW-1:0]        ext_q [3];
  logic signed [CW-1:0] c4_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SW'(pr_q[i][0]) + SW'(pr_q[i][1]) + SW'(pr_q[i][2])
             + (SW'(1) << (EXT_SHIFT - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        ext_q[i] <= sum[i][SW-1:EXT_SHIFT];
        c4_q[i]  <= c3_q[i];
      end
    end
  end

  // Stage 5: bounds with saturation to the coordinate range
  logic signed [DW-1:0] lo [3], hi [3];
  logic signed [CW-1:0] mn_q [3], mx_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo[i] = DW'(c4_q[i]) - $signed({2'b00, ext_q[i]});
      hi[i] = DW'(c4_q[i]) + $signed({2'b00, ext_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mn_q[i] <= (lo[i] < SMIN) ? CW'(SMIN) : (lo[i] > SMAX) ? CW'(SMAX) : CW'(lo[i]);
        mx_q[i] <= (hi[i] < SMIN) ? CW'(SMIN) : (hi[i] > SMAX) ? CW'(SMAX) : CW'(hi[i]);
      end
    end
  end

  assign min_o = mn_q;
  assign max_o = mx_q;

endmodule
`default_nettype wire

// ===== rtl/rbo_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbo_checker
// Port-level checks of the rotated box overlap test unit, bound to the top.
// ----------------------------------------------------------------------------
module rbo_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       s_axis_tready,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata
);

  // Held result stays up
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Held result keeps its data
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Collision flag is the AND of the axis flags, padding is zero
  a_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3] == &m_axis_tdata[2:0]) && (m_axis_tdata[7:4] == 4'b0000))
    else $error("bad result word");

  // Slave side takes a request whenever the output is free
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("pipe stalled with empty output");

  // No result in the cycle after reset was seen
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result during reset");

endmodule

bind rotated_box_overlap_test_unit rbo_checker u_rbo_checker (.*);
`default_nettype wire

// ===== bench/rotated_box_overlap_test_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_box_overlap_test_unit_tb
// Streams box pairs through the overlap unit. A scoreboard predicts the
// per-axis overlap bits and collision flag for each accepted request and
// compares them, in order, with the results. Both sides idle at random, and
// the receiver stalls for a long stretch at least once.
// ----------------------------------------------------------------------------

class overlap_scoreboard;
  bit [3:0] pending_q[$];
  int       errors;

  // Unsigned lane k of a three-lane vector
  static function longint unsigned lane_u(bit [47:0] w, int k);
    return w[k*16 +: 16];
  endfunction

  static function longint lane_s(bit [47:0] w, int k);
    return longint'($signed(w[k*16 +: 16]));
  endfunction

  static function longint unsigned abs_rnd(longint v);
    longint unsigned a;
    a = (v < 0) ? longint'(-v) : v;
    return (a + (64'd1 << 13)) >> 14;
  endfunction

  static function longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // World bounds of one box
  static function void box_limits(bit [47:0] ctr, bit [47:0] sz, bit [47:0] sc,
                                  bit [63:0] q, output longint lo[3],
                                  output longint hi[3]);
    longint unsigned hx[3], ar[3][3], p, e;
    longint qw, qx, qy, qz, one, ext, c;
    qw = longint'($signed(q[15:0]));
    qx = longint'($signed(q[31:16]));
    qy = longint'($signed(q[47:32]));
    qz = longint'($signed(q[63:48]));
    one = 64'd1 << 28;
    for (int i = 0; i < 3; i++) begin
      p = lane_u(sz, i) * lane_u(sc, i);
      hx[i] = (p > 64'h1FF_FFFF) ? 64'h1FF_FFFF : p;
    end
    ar[0][0] = abs_rnd(one - 2 * (qy * qy + qz * qz));
    ar[0][1] = abs_rnd(2 * (qx * qy - qw * qz));
    ar[0][2] = abs_rnd(2 * (qx * qz + qw * qy));
    ar[1][0] = abs_rnd(2 * (qx * qy + qw * qz));
    ar[1][1] = abs_rnd(one - 2 * (qx * qx + qz * qz));
    ar[1][2] = abs_rnd(2 * (qy * qz - qw * qx));
    ar[2][0] = abs_rnd(2 * (qx * qz - qw * qy));
    ar[2][1] = abs_rnd(2 * (qy * qz + qw * qx));
    ar[2][2] = abs_rnd(one - 2 * (qx * qx + qy * qy));
    for (int i = 0; i < 3; i++) begin
      e = 0;
      for (int j = 0; j < 3; j++) e += ar[i][j] * hx[j];
      ext = (e + (64'd1 << 22)) >> 23;
      c = lane_s(ctr, i);
      lo[i] = sat16(c - ext);
      hi[i] = sat16(c + ext);
    end
  endfunction

  function void note_request(bit [415:0] d);
    longint la[3], ha[3], lb[3], hb[3];
    bit [3:0] r;
    box_limits(d[47:0], d[95:48], d[143:96], d[207:144], la, ha);
    box_limits(d[255:208], d[303:256], d[351:304], d[415:352], lb, hb);
    for (int i = 0; i < 3; i++) r[i] = (la[i] <= hb[i]) && (ha[i] >= lb[i]);
    r[3] = &r[2:0];
    pending_q.push_back(r);
  endfunction

  function void check_result(bit [7:0] got);
    bit [3:0] exp_r;
    string nm[4] = '{"overlap_x", "overlap_y", "overlap_z", "colliding"};
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("result %h with none expected", got));
      return;
    end
    exp_r = pending_q.pop_front();
    for (int i = 0; i < 4; i++)
      if (got[i] !== exp_r[i])
        report_mismatch($sformatf("%s got %b exp %b", nm[i], got[i], exp_r[i]));
    if (got[7:4] !== 4'b0) report_mismatch($sformatf("pad bits %b", got[7:4]));
  endfunction

  function void report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endfunction
endclass

module rotated_box_overlap_test_unit_tb;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 1150;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [415:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [7:0]   m_axis_tdata;

  overlap_scoreboard sb = new();
  bit  stim_done = 0;
  int  idle_cycles = 0;

  rotated_box_overlap_test_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One request; waits for the handshake
  task automatic send_request(bit [415:0] d);
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(d);
    @(negedge clk_i);
  endtask

  task automatic send_gap(int n);
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic bit [15:0] rnd_coord();
    case ($urandom_range(0, 4))
      0: return 16'h8000 + 16'($urandom_range(0, 3));
      1: return 16'h7FFF - 16'($urandom_range(0, 3));
      default: return 16'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic bit [47:0] rnd_vec(int lim);
    bit [47:0] v;
    for (int k = 0; k < 3; k++)
      v[k*16 +: 16] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, lim));
    return v;
  endfunction

  // Mostly near-unit quaternions, sometimes raw bits
  function automatic bit [63:0] rnd_quat();
    bit [63:0] q;
    int m;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    m = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++)
      q[k*16 +: 16] = 16'(int'($urandom_range(0, 16384)) - 8192);
    q[m*16 +: 16] = $urandom_range(0, 1) ? 16'd16384 - 16'($urandom_range(0, 4000))
                                           : 16'd0 - (16'd16384 - 16'($urandom_range(0, 4000)));
    return q;
  endfunction

  function automatic bit [415:0] rnd_pair();
    bit [47:0] ca, cb;
    for (int k = 0; k < 3; k++) ca[k*16 +: 16] = rnd_coord();
    cb = ca;
    for (int k = 0; k < 3; k++)
      cb[k*16 +: 16] = ($urandom_range(0, 3) == 0) ? rnd_coord()
                       : ca[k*16 +: 16] + 16'(int'($urandom_range(0, 2000)) - 1000);
    return {rnd_quat(), rnd_vec(600), rnd_vec(600), cb,
            rnd_quat(), rnd_vec(600), rnd_vec(600), ca};
  endfunction

  // Stimulus
  initial begin
    bit [63:0] qid;
    bit [47:0] c0, s1, one3;
    qid  = 64'h0000_0000_0000_4000;
    c0   = '0;
    one3 = {3{16'h0100}};
    s1   = {3{16'h0200}};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // Directed: touching, separated, extremes, non-unit and rotated boxes
    send_request({qid, one3, s1, {16'd0, 16'd0, 16'h0200}, qid, one3, s1, c0});
    send_request({qid, one3, s1, {16'd0, 16'd0, 16'h0201}, qid, one3, s1, c0});
    send_request({qid, one3, s1, {16'h0200, 16'd0, 16'd0}, qid, one3, s1, c0});
    send_request({qid, one3, s1, {16'd0, 16'h0201, 16'd0}, qid, one3, s1, c0});
    send_request({qid, {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'h8000}},
                  qid, {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'h7FFF}}});
    send_request({qid, 48'd0, 48'd0, {3{16'h7FFF}}, qid, 48'd0, 48'd0, {3{16'h8000}}});
    send_request({qid, 48'd0, 48'd0, {3{16'h1234}}, qid, 48'd0, 48'd0, {3{16'h1234}}});
    send_request({64'hFFFF_FFFF_FFFF_FFFF, s1, s1, c0, 64'h8000_8000_8000_8000,
                  s1, s1, {3{16'h0800}}});
    send_request({64'h7FFF_7FFF_7FFF_7FFF, one3, s1, c0, 64'h0000_0000_0000_0000,
                  one3, s1, {3{16'hF000}}});
    send_request({64'h0000_0000_2D41_2D41, one3, {16'h0100, 16'h0100, 16'h0800},
                  {16'd0, 16'd0, 16'h0500}, 64'h2D41_0000_0000_2D41, one3,
                  {16'h0100, 16'h0800, 16'h0100}, c0});
    send_request({64'h2000_2000_2000_2000, one3, s1, c0, 64'h2000_E000_2000_E000,
                  one3, s1, {16'h0100, 16'hFF00, 16'h0080}});
    send_request({rnd_quat(), {3{16'hFFFF}}, {3{16'h0001}}, c0, rnd_quat(),
                  {3{16'h0001}}, {3{16'hFFFF}}, c0});
    for (int i = 0; i < N_RANDOM; i++) begin
      send_request(rnd_pair());
      send_gap(($urandom_range(0, 3) == 0) ? gap_len() : 0);
    end
    s_axis_tvalid <= 0;
    stim_done = 1;
  end

  // Receiver: random backpressure plus one long hold-off
  initial begin
    int g;
    @(posedge rst_ni);
    repeat (200) @(negedge clk_i);
    m_axis_tready <= 0;
    repeat (60) @(negedge clk_i);
    forever begin
      m_axis_tready <= 1;
      @(negedge clk_i);
      if ($urandom_range(0, 4) == 0) begin
        g = gap_len();
        if (g > 0) begin
          m_axis_tready <= 0;
          repeat (g) @(negedge clk_i);
        end
      end
    end
  end

  // Result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending_q.size() != 0 && idle_cycles < WDOG_LIMIT) @(posedge clk_i);
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no progress");
      $display("CHECK FAILED");
    end else begin
      repeat (20) @(posedge clk_i);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
        $display("CHECK OK");
      else
        $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog while stimulus is still running
  initial begin
    wait (idle_cycles >= WDOG_LIMIT && !stim_done);
    $display("watchdog: no progress");
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rbo_pkg.sv
rtl/rbo_box_bounds.sv
rtl/rotated_box_overlap_test_unit.sv
rtl/rbo_checker.sv
bench/rotated_box_overlap_test_unit_tb.sv
